// File: rtl/e2q_pkg.sv
`default_nettype none
package e2q_pkg;

  localparam int AngleBits   = 16;
  localparam int CompBits    = 16;
  localparam int CordicStages = 16;
  localparam int StageBits   = $clog2(CordicStages);
  localparam int CompFrac    = CompBits - 2;
  localparam int IntFrac     = 30;
  // CORDIC datapath width: Q30 values plus headroom for the gain growth.
  localparam int CW          = 34;
  localparam int TolBits     = 16;
  localparam logic [TolBits-1:0] TolReset = 16'd2684;

  localparam logic signed [CW-1:0] CordicGain = 34'sd652032874;
  localparam logic signed [CW-1:0] PiQ30      = 34'sd3373259426;
  localparam logic signed [CW-1:0] HalfPiQ30  = 34'sd1686629713;

  // Norm path widths.
  localparam int N2Bits  = 2 * CompFrac + 3;
  localparam int SqBits  = (N2Bits + 1) / 2;
  localparam int NumBits = 2 * CompFrac + 2;
  localparam int QuoBits = NumBits;

  typedef struct packed {
    logic signed [AngleBits-1:0] pitch_angle;
    logic signed [AngleBits-1:0] yaw_angle;
    logic signed [AngleBits-1:0] roll_angle;
  } in_item_t;

  typedef struct packed {
    logic signed [CompBits-1:0] quat_w;
    logic signed [CompBits-1:0] quat_x;
    logic signed [CompBits-1:0] quat_y;
    logic signed [CompBits-1:0] quat_z;
  } out_item_t;

  // One angle in flight through the CORDIC cell row.
  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
    logic                 neg;
  } rot_t;

  typedef logic signed [CompBits+1:0] comp_t;

  function automatic logic signed [CW-1:0] atan_q30(input int k);
    logic [31:0] t;
    case (k)
      0: t = 32'h3243F6A8;  1: t = 32'h1DAC6705;  2: t = 32'h0FADBAFC;
      3: t = 32'h07F56EA6;  4: t = 32'h03FEAB76;  5: t = 32'h01FFD55B;
      6: t = 32'h00FFFAAA;  7: t = 32'h007FFF55;  8: t = 32'h003FFFEA;
      9: t = 32'h001FFFFD;  10: t = 32'h000FFFFF; 11: t = 32'h0007FFFF;
      12: t = 32'h0003FFFF; 13: t = 32'h0001FFFF; 14: t = 32'h0000FFFF;
      15: t = 32'h00007FFF; 16: t = 32'h00003FFF; 17: t = 32'h00001FFF;
      18: t = 32'h00000FFF; 19: t = 32'h000007FF; 20: t = 32'h000003FF;
      21: t = 32'h000001FF; 22: t = 32'h000000FF; 23: t = 32'h0000007F;
      24: t = 32'h0000003F; 25: t = 32'h0000001F; 26: t = 32'h0000000F;
      27: t = 32'h00000008; 28: t = 32'h00000004; 29: t = 32'h00000002;
      30: t = 32'h00000001;
      default: t = 32'h0;
    endcase
    return $signed({{(CW-32){1'b0}}, t});
  endfunction

endpackage
`default_nettype wire

// File: rtl/e2q_cordic_cell.sv
`default_nettype none
// One CORDIC rotation step for the three angles; registered, advances when enabled.
// The stage input is tied to a constant per cell and selects the shift and arctangent.
module e2q_cordic_cell (
  input  wire logic                              clk,
  input  wire logic                              en,
  input  wire logic [e2q_pkg::StageBits-1:0]     stage,
  input  wire e2q_pkg::rot_t [2:0]               din,
  output e2q_pkg::rot_t [2:0]                    dout
);

  e2q_pkg::rot_t [2:0] nxt;

  // Rotate each angle toward zero; arithmetic shifts floor.
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      nxt[a].neg = din[a].neg;
      if (!din[a].z[e2q_pkg::CW-1]) begin
        nxt[a].x = din[a].x - (din[a].y >>> stage);
        nxt[a].y = din[a].y + (din[a].x >>> stage);
        nxt[a].z = din[a].z - e2q_pkg::atan_q30(int'(stage));
      end else begin
        nxt[a].x = din[a].x + (din[a].y >>> stage);
        nxt[a].y = din[a].y - (din[a].x >>> stage);
        nxt[a].z = din[a].z + e2q_pkg::atan_q30(int'(stage));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout <= nxt;
    end
  end

endmodule
`default_nettype wire

// File: rtl/e2q_div_cell.sv
`default_nettype none
// One restoring-division step for the four component quotients.
module e2q_div_cell (
  input  wire logic                                clk,
  input  wire logic                                en,
  input  wire logic [e2q_pkg::SqBits-1:0]          divisor,
  input  wire logic [3:0][e2q_pkg::NumBits-1:0]    num_in,
  input  wire logic [3:0][e2q_pkg::SqBits:0]       rem_in,
  input  wire logic [3:0][e2q_pkg::QuoBits-1:0]    quo_in,
  output logic [3:0][e2q_pkg::NumBits-1:0]         num_out,
  output logic [3:0][e2q_pkg::SqBits:0]            rem_out,
  output logic [3:0][e2q_pkg::QuoBits-1:0]         quo_out
);

  logic [3:0][e2q_pkg::SqBits+1:0] trial;
  logic [3:0][e2q_pkg::SqBits:0]   rem_next;
  logic [3:0]                      bit_q;

  // Shift in the next numerator bit and subtract the divisor if it fits.
  always_comb begin
    for (int j = 0; j < 4; j++) begin
      trial[j] = {rem_in[j], num_in[j][e2q_pkg::NumBits-1]};
      bit_q[j] = trial[j] >= {2'b00, divisor};
      if (bit_q[j]) begin
        rem_next[j] = (e2q_pkg::SqBits+1)'(trial[j] - {2'b00, divisor});
      end else begin
        rem_next[j] = (e2q_pkg::SqBits+1)'(trial[j]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 4; j++) begin
        num_out[j] <= {num_in[j][e2q_pkg::NumBits-2:0], 1'b0};
        rem_out[j] <= rem_next[j];
        quo_out[j] <= {quo_in[j][e2q_pkg::QuoBits-2:0], bit_q[j]};
      end
    end
  end

endmodule
`default_nettype wire

// File: rtl/euler_to_unit_quaternion.sv
`default_nettype none
// Euler angles to unit quaternion. One conversion is accepted in every cycle
// while out_stall is low; the whole pipeline advances together and stalls as
// one. It is built from 16 CORDIC cells, 5 product and norm stages,
// 16 square-root cells and 30 divider cells, plus the output register.
// The norm_tolerance register may be rewritten only while the pipeline is empty.
module euler_to_unit_quaternion (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire e2q_pkg::in_item_t              in_data,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output e2q_pkg::out_item_t                  out_data,
  input  wire logic                           cfg_we,
  input  wire logic [e2q_pkg::TolBits-1:0]    cfg_data
);

  localparam int CS  = e2q_pkg::CordicStages;
  localparam int CW  = e2q_pkg::CW;
  localparam int SQ  = e2q_pkg::SqBits;
  localparam int NB  = e2q_pkg::NumBits;
  localparam int QB  = e2q_pkg::QuoBits;
  localparam int N2  = e2q_pkg::N2Bits;
  localparam int CF  = e2q_pkg::CompFrac;
  localparam int PB  = 2 * CW;
  localparam int Lat = CS + 5 + SQ + QB;
  localparam logic signed [e2q_pkg::CompBits+1:0] One = (e2q_pkg::CompBits+2)'(1) <<< CF;

  logic [e2q_pkg::TolBits-1:0] norm_tolerance;
  logic                        adv;
  logic [Lat:0]                vld;

  // The whole pipeline moves when the output slot is free.
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      norm_tolerance <= e2q_pkg::TolReset;
    end else if (cfg_we) begin
      norm_tolerance <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[Lat-1:0], in_valid};
    end
  end
  assign out_valid = vld[Lat];

  // Half angle to Q30 and fold into the CORDIC range.
  e2q_pkg::rot_t [2:0] rot [CS+1];
  logic signed [e2q_pkg::AngleBits-1:0] ang [3];

  always_comb begin
    logic signed [CW-1:0] th;
    ang[0] = in_data.pitch_angle;
    ang[1] = in_data.yaw_angle;
    ang[2] = in_data.roll_angle;
    for (int a = 0; a < 3; a++) begin
      th = CW'(ang[a]) <<< (32 - e2q_pkg::AngleBits);
      rot[0][a].x   = e2q_pkg::CordicGain;
      rot[0][a].y   = '0;
      rot[0][a].neg = 1'b0;
      rot[0][a].z   = th;
      if (th > e2q_pkg::HalfPiQ30) begin
        rot[0][a].z   = th - e2q_pkg::PiQ30;
        rot[0][a].neg = 1'b1;
      end else if (th < -e2q_pkg::HalfPiQ30) begin
        rot[0][a].z   = th + e2q_pkg::PiQ30;
        rot[0][a].neg = 1'b1;
      end
    end
  end

  for (genvar g = 0; g < CS; g++) begin : g_cordic
    e2q_cordic_cell u_cell (
      .clk  (clk),
      .en   (adv),
      .stage(e2q_pkg::StageBits'(g)),
      .din  (rot[g]),
      .dout (rot[g+1])
    );
  end

  // Signed sine and cosine of each half angle (index 0 pitch, 1 yaw, 2 roll).
  logic signed [CW-1:0] sn [3];
  logic signed [CW-1:0] cs [3];
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      sn[a] = rot[CS][a].neg ? -rot[CS][a].y : rot[CS][a].y;
      cs[a] = rot[CS][a].neg ? -rot[CS][a].x : rot[CS][a].x;
    end
  end

  function automatic logic signed [CW-1:0] mulq(input logic signed [CW-1:0] a,
                                               input logic signed [CW-1:0] b);
    logic signed [PB-1:0] p;
    p = PB'(a) * PB'(b) + (PB'(1) <<< (e2q_pkg::IntFrac - 1));
    return CW'(p >>> e2q_pkg::IntFrac);
  endfunction

  // Stage 1: pairwise products of roll and pitch terms.
  logic signed [CW-1:0] crcp, srsp, srcp, crsp, cy1, sy1;
  always_ff @(posedge clk) begin
    if (adv) begin
      crcp <= mulq(cs[2], cs[0]);
      srsp <= mulq(sn[2], sn[0]);
      srcp <= mulq(sn[2], cs[0]);
      crsp <= mulq(cs[2], sn[0]);
      cy1  <= cs[1];
      sy1  <= sn[1];
    end
  end

  // Stage 2: products with yaw terms.
  logic signed [CW-1:0] p_cc_c, p_ss_s, p_sc_c, p_cs_s, p_cs_c, p_sc_s, p_cc_s, p_ss_c;
  always_ff @(posedge clk) begin
    if (adv) begin
      p_cc_c <= mulq(crcp, cy1);
      p_ss_s <= mulq(srsp, sy1);
      p_sc_c <= mulq(srcp, cy1);
      p_cs_s <= mulq(crsp, sy1);
      p_cs_c <= mulq(crsp, cy1);
      p_sc_s <= mulq(srcp, sy1);
      p_cc_s <= mulq(crcp, sy1);
      p_ss_c <= mulq(srsp, cy1);
    end
  end

  function automatic e2q_pkg::comp_t to_comp(input logic signed [CW-1:0] v);
    logic signed [CW-1:0] t;
    t = v + (CW'(1) <<< (e2q_pkg::IntFrac - CF - 1));
    return (e2q_pkg::CompBits+2)'(t >>> (e2q_pkg::IntFrac - CF));
  endfunction

  // Stage 3: components in Q3.14.
  e2q_pkg::comp_t q3 [4];
  always_ff @(posedge clk) begin
    if (adv) begin
      q3[0] <= to_comp(p_cc_c + p_ss_s);
      q3[1] <= to_comp(p_sc_c - p_cs_s);
      q3[2] <= to_comp(p_cs_c + p_sc_s);
      q3[3] <= to_comp(p_cc_s - p_ss_c);
    end
  end

  // Stage 4: squares of magnitudes.
  logic [e2q_pkg::CompBits:0] mag4 [4];
  logic [N2-1:0]              sq4 [4];
  logic [3:0]                 sgn4;
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < 4; j++) begin
        logic [e2q_pkg::CompBits:0] m;
        m = q3[j][e2q_pkg::CompBits+1] ? (e2q_pkg::CompBits+1)'(-q3[j])
                                       : (e2q_pkg::CompBits+1)'(q3[j]);
        mag4[j] <= m;
        sgn4[j] <= q3[j][e2q_pkg::CompBits+1];
        sq4[j]  <= N2'(m) * N2'(m);
      end
    end
  end

  // Stage 5: squared norm and the tolerance decision.
  logic [N2-1:0]              n2;
  logic [e2q_pkg::CompBits:0] mag5 [4];
  logic [3:0]                 sgn5;
  logic                       fix5;
  always_ff @(posedge clk) begin
    if (adv) begin
      logic [N2-1:0] s, unit, dev;
      s    = sq4[0] + sq4[1] + sq4[2] + sq4[3];
      unit = N2'(1) << (2 * CF);
      dev  = (s > unit) ? s - unit : unit - s;
      n2   <= s;
      fix5 <= (s != '0) && (dev > N2'(norm_tolerance));
      mag5 <= mag4;
      sgn5 <= sgn4;
    end
  end

  // Square root: one result bit per cell, digit by digit, over the norm padded to 2*SQ bits.
  logic [N2+1:0]   sq_rem [SQ+1];
  logic [SQ-1:0]   sq_root [SQ+1];
  logic [2*SQ-1:0] sq_n [SQ+1];
  logic [e2q_pkg::CompBits:0] sq_mag [SQ+1][4];
  logic [3:0] sq_sgn [SQ+1];
  logic       sq_fix [SQ+1];
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_n[0]    = (2 * SQ)'(n2);
  assign sq_mag[0]  = mag5;
  assign sq_sgn[0]  = sgn5;
  assign sq_fix[0]  = fix5;

  for (genvar g = 0; g < SQ; g++) begin : g_sqrt
    logic [N2+1:0] tr, rr;
    logic [SQ-1:0] rt;
    always_comb begin
      rr = {sq_rem[g][N2-1:0], sq_n[g][2*SQ-1 -: 2]};
      tr = (N2+2)'({sq_root[g], 2'b01});
      rt = {sq_root[g][SQ-2:0], 1'b0};
      if (rr >= tr) begin
        rr = rr - tr;
        rt = {sq_root[g][SQ-2:0], 1'b1};
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        sq_rem[g+1]  <= rr;
        sq_root[g+1] <= rt;
        sq_n[g+1]    <= {sq_n[g][2*SQ-3:0], 2'b00};
        sq_mag[g+1]  <= sq_mag[g];
        sq_sgn[g+1]  <= sq_sgn[g];
        sq_fix[g+1]  <= sq_fix[g];
      end
    end
  end

  // Divider: rounded numerator |q|*2^14 + s/2, one quotient bit per cell.
  logic [SQ-1:0] dvs;
  assign dvs = (sq_root[SQ] == '0) ? SQ'(1) : sq_root[SQ];

  logic [3:0][NB-1:0] dnum [QB+1];
  logic [3:0][SQ:0]   drem [QB+1];
  logic [3:0][QB-1:0] dquo [QB+1];
  logic [SQ-1:0]      ddiv [QB+1];
  logic [e2q_pkg::CompBits:0] dmag [QB+1][4];
  logic [3:0]         dsgn [QB+1];
  logic               dfix [QB+1];

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      dnum[0][j] = NB'({sq_mag[SQ][j], CF'(0)}) + NB'(dvs >> 1);
      drem[0][j] = '0;
      dquo[0][j] = '0;
    end
  end
  assign ddiv[0] = dvs;
  assign dmag[0] = sq_mag[SQ];
  assign dsgn[0] = sq_sgn[SQ];
  assign dfix[0] = sq_fix[SQ];

  for (genvar g = 0; g < QB; g++) begin : g_div
    e2q_div_cell u_cell (
      .clk    (clk),
      .en     (adv),
      .divisor(ddiv[g]),
      .num_in (dnum[g]),
      .rem_in (drem[g]),
      .quo_in (dquo[g]),
      .num_out(dnum[g+1]),
      .rem_out(drem[g+1]),
      .quo_out(dquo[g+1])
    );
    always_ff @(posedge clk) begin
      if (adv) begin
        ddiv[g+1] <= ddiv[g];
        dmag[g+1] <= dmag[g];
        dsgn[g+1] <= dsgn[g];
        dfix[g+1] <= dfix[g];
      end
    end
  end

  // Output register: pick divided or original magnitude, then saturate.
  always_ff @(posedge clk) begin
    if (adv) begin
      logic [QB-1:0] m;
      logic [e2q_pkg::CompBits-1:0] v [4];
      for (int j = 0; j < 4; j++) begin
        m = dfix[QB] ? dquo[QB][j] : QB'(dmag[QB][j]);
        if (m > QB'(One)) begin
          m = QB'(One);
        end
        v[j] = dsgn[QB][j] ? e2q_pkg::CompBits'(-m) : e2q_pkg::CompBits'(m);
      end
      out_data.quat_w <= v[0];
      out_data.quat_x <= v[1];
      out_data.quat_y <= v[2];
      out_data.quat_z <= v[3];
    end
  end

endmodule
`default_nettype wire

// File: tb/sv/euler_to_unit_quaternion_tb.sv
`timescale 1ns / 1ps
module euler_to_unit_quaternion_tb;

  localparam int GapMax = 14;
  localparam int DrainCycles = 90;
  localparam longint Gain = 64'sd652032874;
  localparam longint PiVal = 64'sd3373259426;
  localparam longint HalfPi = 64'sd1686629713;
  localparam longint CompOne = 64'sd16384;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  e2q_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  e2q_pkg::out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [e2q_pkg::TolBits-1:0] cfg_data = '0;

  logic [e2q_pkg::TolBits-1:0] tol_shadow = e2q_pkg::TolReset;
  e2q_pkg::out_item_t quat_queue[$];
  bit failed = 0;
  bit burst = 0;
  bit hold_long = 0;

  // One row of the directed stimulus.
  typedef struct {
    logic signed [15:0] p;
    logic signed [15:0] y;
    logic signed [15:0] r;
  } angle_row_t;

  angle_row_t angle_rows[] = '{
    '{16'sd0, 16'sd0, 16'sd0}, '{16'sd32767, 16'sd32767, 16'sd32767},
    '{-16'sd32768, -16'sd32768, -16'sd32768}, '{16'sd32767, -16'sd32768, 16'sd0},
    '{16'sd25735, 16'sd0, 16'sd0}, '{16'sd25736, 16'sd0, 16'sd0},
    '{-16'sd25735, 16'sd0, 16'sd0}, '{-16'sd25736, 16'sd0, 16'sd0},
    '{16'sd0, 16'sd25736, 16'sd0}, '{16'sd0, 16'sd0, -16'sd25736},
    '{16'sd12868, 16'sd12868, 16'sd12868}, '{-16'sd12868, 16'sd6434, 16'sd19302},
    '{16'sd1, -16'sd1, 16'sd1}, '{-16'sd1, -16'sd1, -16'sd1},
    '{16'sd8192, -16'sd8192, 16'sd16384}, '{16'sh5555, -16'sh5556, 16'sh2AAA},
    '{16'sd25736, 16'sd25736, 16'sd25736}, '{-16'sd25736, 16'sd32767, -16'sd32768}
  };

  euler_to_unit_quaternion u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Fixed-point helpers for the conversion.
  function automatic longint mul_round(longint a, longint b);
    return (a * b + (64'sd1 <<< 29)) >>> 30;
  endfunction

  function automatic void half_sin_cos(logic signed [15:0] ang, output longint s,
                                       output longint c);
    longint th, xv, yv, nx;
    bit flip;
    th = longint'(ang) * 65536;
    xv = Gain;
    yv = 0;
    flip = 0;
    if (th > HalfPi) begin
      th -= PiVal;
      flip = 1;
    end else if (th < -HalfPi) begin
      th += PiVal;
      flip = 1;
    end
    for (int i = 0; i < e2q_pkg::CordicStages; i++) begin
      if (th >= 0) begin
        nx = xv - (yv >>> i);
        yv = yv + (xv >>> i);
        th -= longint'(e2q_pkg::atan_q30(i));
      end else begin
        nx = xv + (yv >>> i);
        yv = yv - (xv >>> i);
        th += longint'(e2q_pkg::atan_q30(i));
      end
      xv = nx;
    end
    s = flip ? -yv : yv;
    c = flip ? -xv : xv;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  // Expected quaternion for one set of angles under a given tolerance.
  function automatic e2q_pkg::out_item_t quat_of_angles(e2q_pkg::in_item_t a,
                                                        logic [e2q_pkg::TolBits-1:0] tol);
    longint sp, cp, sy, cy, sr, cr;
    longint q[4];
    longint unsigned n2, dev, root, mag, quo;
    e2q_pkg::out_item_t res;
    half_sin_cos(a.pitch_angle, sp, cp);
    half_sin_cos(a.yaw_angle, sy, cy);
    half_sin_cos(a.roll_angle, sr, cr);
    q[0] = mul_round(mul_round(cr, cp), cy) + mul_round(mul_round(sr, sp), sy);
    q[1] = mul_round(mul_round(sr, cp), cy) - mul_round(mul_round(cr, sp), sy);
    q[2] = mul_round(mul_round(cr, sp), cy) + mul_round(mul_round(sr, cp), sy);
    q[3] = mul_round(mul_round(cr, cp), sy) - mul_round(mul_round(sr, sp), cy);
    n2 = 0;
    for (int j = 0; j < 4; j++) begin
      q[j] = (q[j] + (64'sd1 <<< 15)) >>> 16;
      mag = (q[j] < 0) ? -q[j] : q[j];
      n2 += mag * mag;
    end
    dev = (n2 > (64'd1 << 28)) ? n2 - (64'd1 << 28) : (64'd1 << 28) - n2;
    // Renormalize only when the norm is nonzero and outside the tolerance.
    if (n2 != 0 && dev > tol) begin
      root = int_sqrt(n2);
      if (root == 0) root = 1;
      for (int j = 0; j < 4; j++) begin
        mag = (q[j] < 0) ? -q[j] : q[j];
        quo = ((mag << 14) + (root >> 1)) / root;
        if (quo > CompOne) quo = CompOne;
        q[j] = (q[j] < 0) ? -longint'(quo) : longint'(quo);
      end
    end
    for (int j = 0; j < 4; j++) begin
      if (q[j] > CompOne) q[j] = CompOne;
      if (q[j] < -CompOne) q[j] = -CompOne;
    end
    res.quat_w = q[0][15:0];
    res.quat_x = q[1][15:0];
    res.quat_y = q[2][15:0];
    res.quat_z = q[3][15:0];
    return res;
  endfunction

  // Offer one set of angles and wait for its transfer.
  task automatic send_angles(e2q_pkg::in_item_t a);
    int gap;
    gap = burst ? 0 : $urandom_range(GapMax, 0);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= a;
    do @(posedge clk); while (in_stall);
    quat_queue.push_back(quat_of_angles(a, tol_shadow));
  endtask

  task automatic drain_and_write(logic [e2q_pkg::TolBits-1:0] tol);
    in_valid <= 1'b0;
    while (quat_queue.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= tol;
    @(posedge clk);
    cfg_we <= 1'b0;
    tol_shadow = tol;
  endtask

  function automatic e2q_pkg::in_item_t random_angles();
    e2q_pkg::in_item_t a;
    a.pitch_angle = 16'($urandom);
    a.yaw_angle = 16'($urandom);
    a.roll_angle = 16'($urandom);
    return a;
  endfunction

  // Receiver back-pressure, with one long hold while the sender keeps going.
  initial begin
    int n;
    forever begin
      @(posedge clk);
      if (hold_long) begin
        out_stall <= 1'b1;
        repeat (400) @(posedge clk);
        hold_long = 0;
        out_stall <= 1'b0;
      end else if (burst) begin
        out_stall <= 1'b0;
      end else begin
        n = $urandom_range(GapMax, 0);
        if (n > 0) begin
          out_stall <= 1'b1;
          repeat (n) @(posedge clk);
        end
        out_stall <= 1'b0;
        do @(posedge clk); while (!(out_valid && !out_stall) && !hold_long && !burst);
      end
    end
  end

  // Compare every output transfer with the oldest expected quaternion.
  always @(posedge clk) begin
    e2q_pkg::out_item_t exp_q;
    if (!rst && out_valid && !out_stall) begin
      if (quat_queue.size() == 0) begin
        $error("unexpected output transfer %h", out_data);
        failed = 1;
      end else begin
        exp_q = quat_queue.pop_front();
        if (out_data.quat_w !== exp_q.quat_w) begin
          $error("quat_w expected %0d actual %0d", exp_q.quat_w, out_data.quat_w);
          failed = 1;
        end
        if (out_data.quat_x !== exp_q.quat_x) begin
          $error("quat_x expected %0d actual %0d", exp_q.quat_x, out_data.quat_x);
          failed = 1;
        end
        if (out_data.quat_y !== exp_q.quat_y) begin
          $error("quat_y expected %0d actual %0d", exp_q.quat_y, out_data.quat_y);
          failed = 1;
        end
        if (out_data.quat_z !== exp_q.quat_z) begin
          $error("quat_z expected %0d actual %0d", exp_q.quat_z, out_data.quat_z);
          failed = 1;
        end
      end
    end
  end

  initial begin
    #4000000;
    $display("euler_to_unit_quaternion: mismatch");
    $finish;
  end

  initial begin
    logic [e2q_pkg::TolBits-1:0] tols[6];
    e2q_pkg::in_item_t a;
    tols = '{16'd0, 16'd65535, 16'd1, 16'd0, 16'd0, e2q_pkg::TolReset};
    tols[3] = 16'($urandom);
    tols[4] = 16'($urandom_range(4000, 0));
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed rows under the reset tolerance, then under zero tolerance.
    for (int pass = 0; pass < 2; pass++) begin
      foreach (angle_rows[k]) begin
        a.pitch_angle = angle_rows[k].p;
        a.yaw_angle = angle_rows[k].y;
        a.roll_angle = angle_rows[k].r;
        send_angles(a);
      end
      if (pass == 0) drain_and_write(16'd0);
    end

    // Random phases across several tolerance settings.
    foreach (tols[t]) begin
      drain_and_write(tols[t]);
      burst = (t == 2);
      for (int i = 0; i < 175; i++) begin
        if (t == 1 && i == 20) hold_long = 1;
        send_angles(random_angles());
      end
      burst = 0;
    end

    in_valid <= 1'b0;
    while (quat_queue.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (!failed) begin
      $display("euler_to_unit_quaternion: match");
    end else begin
      $display("euler_to_unit_quaternion: mismatch");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/e2q_pkg.sv
rtl/e2q_cordic_cell.sv
rtl/e2q_div_cell.sv
rtl/euler_to_unit_quaternion.sv
tb/sv/euler_to_unit_quaternion_tb.sv
